// File: design/json_brace_framer_with_raw_core_assert.svh
// Assertion helpers for the brace framer, sampled on clk_i, off while rst_ni is low.
`ifndef JSON_BRACE_FRAMER_WITH_RAW_CORE_ASSERT_SVH
`define JSON_BRACE_FRAMER_WITH_RAW_CORE_ASSERT_SVH

// Same-cycle implication.
`define JBF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("framer check failed");

// Next-cycle implication.
`define JBF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("framer check failed");

`endif

// File: design/jbf_pkg.sv
package jbf_pkg;

  localparam int unsigned MAX_DEPTH  = 255;
  localparam int unsigned DEPTH_W    = 8;
  localparam int unsigned LEN_BITS   = 32;
  localparam int unsigned ACC_W      = LEN_BITS + 4;
  localparam int unsigned PREFIX_LEN = 7;
  localparam int unsigned HELD_W     = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RAW_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_AFTER = 2'd1;

  // Result kinds
  localparam logic [1:0] KIND_OBJECT  = 2'd0;
  localparam logic [1:0] KIND_HEADER  = 2'd1;
  localparam logic [1:0] KIND_PAYLOAD = 2'd2;
  localparam logic [1:0] KIND_STATUS  = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_UNBAL    = 2'd1;
  localparam logic [1:0] ERR_BAD_LEN  = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  // Stream characters
  localparam logic [7:0] CH_OPEN   = 8'h7B;
  localparam logic [7:0] CH_CLOSE  = 8'h7D;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Raw header prefix: {"RAW":
  localparam logic [7:0] RAW_TAG [PREFIX_LEN] = '{8'h7B, 8'h22, 8'h52, 8'h41, 8'h57, 8'h22, 8'h3A};

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] out_kind;
    logic       frame_end;
    logic [1:0] error_code;
  } res_t;

endpackage

// File: design/jbf_in_if.sv
interface jbf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// File: design/jbf_out_if.sv
interface jbf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       frame_end;
  logic [1:0] error_code;

  modport source (output valid, output out_byte, output out_kind, output frame_end,
                  output error_code, input ready);
  modport sink   (input valid, input out_byte, input out_kind, input frame_end,
                  input error_code, output ready);
endinterface

// File: design/jbf_cfg_if.sv
interface jbf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [jbf_pkg::CFG_IDX_W-1:0]   index;
  logic [jbf_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/json_brace_framer_with_raw_core.sv
// JSON brace framer with raw payload headers. Takes one stream byte per request on in_i
// and frames JSON objects by counting braces not preceded by a backslash (the escape
// check looks at the previous byte, whatever mode it arrived in). Bytes outside an
// object are dropped; a stray close brace gives a status-only result with error 1, and an
// open brace at depth 255 gives error 3 and drops the object. The first seven bytes of
// an object are held; when the seventh arrives (or the object closes earlier) they are
// released as a burst, tagged as raw header bytes if they read {"RAW": and raw_enable is
// set. A header's decimal value (saturated to 32 bits) sets how many payload bytes
// follow; a header with no digits ends with error 2. With skip_after_payload set, one
// byte after a payload (or after a zero-length header) is dropped. Rate: one byte is
// taken per cycle while no burst runs and the output queue has room, and at most one
// result leaves per cycle; during a prefix release in_i.ready stays low while the
// burst sequencer walks the prefix buffer. Results pass through a two-entry output
// queue, so a byte is still taken while a result waits on out_o. cfg_i is always ready;
// write it only while the framer is idle.
module json_brace_framer_with_raw_core (
  input  logic            clk_i,
  input  logic            rst_ni,
  jbf_in_if.sink          in_i,
  jbf_out_if.source       out_o,
  jbf_cfg_if.sink         cfg_i
);

  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_OBJECT  = 2'd1;
  localparam logic [1:0] MODE_PAYLOAD = 2'd2;
  localparam logic [1:0] MODE_SKIP    = 2'd3;

  // Length parse phases
  localparam logic [1:0] LP_BEFORE   = 2'd0;
  localparam logic [1:0] LP_DIGITS   = 2'd1;
  localparam logic [1:0] LP_NONE     = 2'd2;
  localparam logic [1:0] LP_DONE     = 2'd3;

  localparam int unsigned DW = jbf_pkg::DEPTH_W;
  localparam int unsigned LW = jbf_pkg::LEN_BITS;
  localparam int unsigned AW = jbf_pkg::ACC_W;
  localparam int unsigned HW = jbf_pkg::HELD_W;
  localparam int unsigned PL = jbf_pkg::PREFIX_LEN;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic raw_en_q, skip_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_en_q <= 1'b1;
      skip_q   <= 1'b1;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        jbf_pkg::CFG_RAW_ENABLE: raw_en_q <= cfg_i.data[0];
        jbf_pkg::CFG_SKIP_AFTER: skip_q   <= cfg_i.data[0];
        default: ;  // unmapped index, ignore
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Framer state
  // ---------------------------------------------------------------------------
  logic [1:0]    mode_q, mode_d;
  logic [DW-1:0] depth_q, depth_d;
  logic [7:0]    prev_q;
  logic [7:0]    hold_q [PL];
  logic [HW-1:0] held_q, held_d;
  logic          raw_q, raw_d;
  logic [LW-1:0] acc_q, acc_d;
  logic [LW-1:0] left_q, left_d;
  logic [1:0]    phase_q, phase_d;

  // Burst sequencer over the prefix buffer
  logic [HW-1:0] burst_cnt_q, burst_idx_q;
  logic          burst_raw_q, burst_end_q;
  logic [1:0]    burst_err_q;

  // Output queue
  jbf_pkg::res_t fifo_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    fcnt_q;

  logic in_acc, out_pop, room, push, burst_act, burst_last;
  jbf_pkg::res_t push_res, burst_res;

  assign burst_act  = (burst_cnt_q != '0);
  assign out_pop    = out_o.valid && out_o.ready;
  assign room       = (fcnt_q != 2'd2) || out_pop;
  assign in_i.ready = !burst_act && room;
  assign in_acc     = in_i.valid && in_i.ready;

  // ---------------------------------------------------------------------------
  // Per-byte decode
  // ---------------------------------------------------------------------------
  logic [7:0]    b;
  logic          esc, is_open, is_close, digit, blank;
  logic [AW-1:0] acc_sum;
  logic [LW-1:0] acc_sat, acc_p;
  logic [1:0]    phase_p;

  assign b        = in_i.in_byte;
  assign esc      = (prev_q == jbf_pkg::CH_BSLASH);
  assign is_open  = (b == jbf_pkg::CH_OPEN) && !esc;
  assign is_close = (b == jbf_pkg::CH_CLOSE) && !esc;
  assign digit    = (b >= jbf_pkg::CH_ZERO) && (b <= jbf_pkg::CH_NINE);
  assign blank    = (b == jbf_pkg::CH_SPACE) || (b == jbf_pkg::CH_TAB) ||
                    (b == jbf_pkg::CH_QUOTE);

  // acc * 10 + digit as (acc << 3) + (acc << 1) + digit, saturated
  assign acc_sum = AW'({acc_q, 3'b000}) + AW'({acc_q, 1'b0}) + AW'(b[3:0]);
  assign acc_sat = (acc_sum[AW-1:LW] != '0) ? '1 : acc_sum[LW-1:0];

  always_comb begin
    phase_p = phase_q;
    acc_p   = acc_q;
    case (phase_q)
      LP_BEFORE: begin
        if (digit) begin
          phase_p = LP_DIGITS;
          acc_p   = acc_sat;
        end else if (!blank) begin
          phase_p = LP_NONE;
        end
      end
      LP_DIGITS: begin
        if (digit) acc_p = acc_sat;
        else phase_p = LP_DONE;
      end
      default: ;  // value already ended
    endcase
  end

  logic          match;
  logic          hold_we;
  logic          single_v;
  jbf_pkg::res_t single;
  logic          burst_load, burst_raw, burst_end;
  logic [1:0]    burst_err;
  logic [HW-1:0] burst_n;
  logic [DW-1:0] depth_n;
  logic          raw_n, closed;
  logic [LW-1:0] acc_n;
  logic [1:0]    phase_n, after_mode;

  // Raw tag: six held bytes plus the seventh arriving now
  always_comb begin
    match = raw_en_q && (b == jbf_pkg::RAW_TAG[PL-1]);
    for (int i = 0; i < PL - 1; i++) begin
      if (hold_q[i] != jbf_pkg::RAW_TAG[i]) match = 1'b0;
    end
  end

  assign after_mode = skip_q ? MODE_SKIP : MODE_IDLE;

  always_comb begin
    mode_d     = mode_q;
    depth_d    = depth_q;
    held_d     = held_q;
    raw_d      = raw_q;
    acc_d      = acc_q;
    left_d     = left_q;
    phase_d    = phase_q;
    hold_we    = 1'b0;
    single_v   = 1'b0;
    single     = '0;
    burst_load = 1'b0;
    burst_n    = '0;
    burst_raw  = 1'b0;
    burst_end  = 1'b0;
    burst_err  = jbf_pkg::ERR_NONE;
    depth_n    = depth_q;
    raw_n      = raw_q;
    acc_n      = acc_q;
    phase_n    = phase_q;
    closed     = 1'b0;

    unique case (mode_q)
      MODE_IDLE: begin
        if (is_open) begin
          // start an object: first byte goes to the prefix buffer
          mode_d  = MODE_OBJECT;
          depth_d = DW'(1);
          held_d  = HW'(1);
          hold_we = 1'b1;
          raw_d   = 1'b0;
          acc_d   = '0;
          left_d  = '0;
          phase_d = LP_BEFORE;
        end else if (is_close) begin
          single_v          = 1'b1;
          single.out_kind   = jbf_pkg::KIND_STATUS;
          single.error_code = jbf_pkg::ERR_UNBAL;
          depth_d = '0;
          held_d  = '0;
          raw_d   = 1'b0;
          acc_d   = '0;
          left_d  = '0;
          phase_d = LP_BEFORE;
        end
      end

      MODE_SKIP: mode_d = MODE_IDLE;  // drop the separator

      MODE_PAYLOAD: begin
        single_v          = 1'b1;
        single.out_byte   = b;
        single.out_kind   = jbf_pkg::KIND_PAYLOAD;
        single.frame_end  = (left_q <= LW'(1));
        if (left_q <= LW'(1)) begin
          left_d = '0;
          mode_d = after_mode;
        end else begin
          left_d = left_q - LW'(1);
        end
      end

      MODE_OBJECT: begin
        if (is_open && (depth_q >= DW'(jbf_pkg::MAX_DEPTH))) begin
          // overflow: report and drop whatever is still held
          single_v          = 1'b1;
          single.out_kind   = jbf_pkg::KIND_STATUS;
          single.error_code = jbf_pkg::ERR_OVERFLOW;
          mode_d  = MODE_IDLE;
          depth_d = '0;
          held_d  = '0;
          raw_d   = 1'b0;
          acc_d   = '0;
          left_d  = '0;
          phase_d = LP_BEFORE;
        end else begin
          if (is_open) depth_n = depth_q + DW'(1);
          else if (is_close && (depth_q != '0)) depth_n = depth_q - DW'(1);
          closed = (depth_n == '0);

          if (held_q < HW'(PL)) begin
            hold_we = 1'b1;
            held_d  = held_q + HW'(1);
            if (held_q == HW'(PL - 1)) begin
              raw_n      = match;
              burst_load = 1'b1;
              burst_n    = HW'(PL);
            end else if (closed) begin
              burst_load = 1'b1;
              burst_n    = held_q + HW'(1);
            end
            burst_raw = raw_n;
            burst_end = closed;
          end else begin
            if (raw_q) begin
              acc_n   = acc_p;
              phase_n = phase_p;
            end
            single_v         = 1'b1;
            single.out_byte  = b;
            single.out_kind  = {1'b0, raw_q};
            single.frame_end = closed;
          end

          if (closed) begin
            mode_d = MODE_IDLE;
            if (raw_n) begin
              if ((phase_n == LP_DIGITS) || (phase_n == LP_DONE)) begin
                left_d = acc_n;
                mode_d = (acc_n != '0) ? MODE_PAYLOAD : after_mode;
              end else begin
                // header without digits: flag its closing byte
                single.error_code = jbf_pkg::ERR_BAD_LEN;
                burst_err         = jbf_pkg::ERR_BAD_LEN;
              end
            end
            depth_d = '0;
            held_d  = '0;
            raw_d   = 1'b0;
            acc_d   = '0;
            phase_d = LP_BEFORE;
          end else begin
            depth_d = depth_n;
            raw_d   = raw_n;
            acc_d   = acc_n;
            phase_d = phase_n;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      depth_q <= '0;
      prev_q  <= '0;
      held_q  <= '0;
      raw_q   <= 1'b0;
      acc_q   <= '0;
      left_q  <= '0;
      phase_q <= LP_BEFORE;
    end else if (in_acc) begin
      mode_q  <= mode_d;
      depth_q <= depth_d;
      prev_q  <= b;
      held_q  <= held_d;
      raw_q   <= raw_d;
      acc_q   <= acc_d;
      left_q  <= left_d;
      phase_q <= phase_d;
    end
  end

  // Prefix buffer; no reset, an entry is always written before the burst reads it
  always_ff @(posedge clk_i) begin
    if (in_acc && hold_we) hold_q[held_q] <= b;
  end

  // ---------------------------------------------------------------------------
  // Burst sequencer: while the output queue has room, release held bytes one per cycle
  // ---------------------------------------------------------------------------
  assign burst_last = (burst_idx_q == burst_cnt_q - HW'(1));

  always_comb begin
    burst_res            = '0;
    burst_res.out_byte   = hold_q[burst_idx_q];
    burst_res.out_kind   = {1'b0, burst_raw_q};
    burst_res.frame_end  = burst_last && burst_end_q;
    burst_res.error_code = burst_last ? burst_err_q : jbf_pkg::ERR_NONE;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_cnt_q <= '0;
      burst_idx_q <= '0;
      burst_raw_q <= 1'b0;
      burst_end_q <= 1'b0;
      burst_err_q <= jbf_pkg::ERR_NONE;
    end else if (burst_act) begin
      if (room) begin
        if (burst_last) begin
          burst_cnt_q <= '0;
          burst_idx_q <= '0;
        end else begin
          burst_idx_q <= burst_idx_q + HW'(1);
        end
      end
    end else if (in_acc && burst_load) begin
      burst_cnt_q <= burst_n;
      burst_idx_q <= '0;
      burst_raw_q <= burst_raw;
      burst_end_q <= burst_end;
      burst_err_q <= burst_err;
    end
  end

  // ---------------------------------------------------------------------------
  // Output queue: burst bytes first, else the result of this cycle's request
  // ---------------------------------------------------------------------------
  assign push     = burst_act ? room : (in_acc && single_v);
  assign push_res = burst_act ? burst_res : single;

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= push_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fcnt_q <= '0;
    end else begin
      if (push) wr_q <= ~wr_q;
      if (out_pop) rd_q <= ~rd_q;
      if (push && !out_pop) fcnt_q <= fcnt_q + 2'd1;
      else if (!push && out_pop) fcnt_q <= fcnt_q - 2'd1;
    end
  end

  assign out_o.valid      = (fcnt_q != '0);
  assign out_o.out_byte   = fifo_q[rd_q].out_byte;
  assign out_o.out_kind   = fifo_q[rd_q].out_kind;
  assign out_o.frame_end  = fifo_q[rd_q].frame_end;
  assign out_o.error_code = fifo_q[rd_q].error_code;

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
`include "json_brace_framer_with_raw_core_assert.svh"

  `JBF_ASSERT_NOW(a_queue_bound, 1'b1, fcnt_q != 2'd3)
  `JBF_ASSERT_NOW(a_no_take_in_burst, burst_act, !in_i.ready)
  `JBF_ASSERT_NOW(a_payload_nonzero, mode_q == MODE_PAYLOAD, left_q != '0)
  `JBF_ASSERT_NOW(a_status_clean,
                  out_o.valid && (out_o.out_kind == jbf_pkg::KIND_STATUS),
                  (out_o.out_byte == '0) && !out_o.frame_end)
  `JBF_ASSERT_NEXT(a_burst_starts, in_acc && burst_load, burst_act)

endmodule

// File: test/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CLK_PERIOD   = 4;
  localparam int unsigned RESET_CYCLES = 11;
  // Prefix burst plus the two-entry output queue, with margin.
  localparam int unsigned QUIET_CYCLES = 32;
  localparam int unsigned PHASE_BYTES  = 24;
  localparam longint unsigned LIMIT_NS = 64'd8_000_000;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_FILL    = 8'h78;  // 'x', neutral everywhere

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_OBJECT,
    MODE_PAYLOAD,
    MODE_SKIP
  } framer_mode_e;

  typedef enum logic [1:0] {
    LEN_WAIT,     // value not started, blanks and quotes still allowed
    LEN_DIGITS,   // inside the digit run
    LEN_NONE,     // value ended before any digit
    LEN_DONE      // value ended after digits
  } len_phase_e;

  logic clk_i = 1'b0;
  logic rst_ni;

  jbf_in_if  in_if ();
  jbf_out_if out_if ();
  jbf_cfg_if cfg_if ();

  json_brace_framer_with_raw_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ------------------------------------------------------------------
  // Framer shadow: register copies and framing state, advanced once per
  // accepted request.
  // ------------------------------------------------------------------
  bit           shadow_raw_en = 1'b1;
  bit           shadow_skip   = 1'b1;
  int unsigned  depth_now     = 0;
  logic [7:0]   last_byte     = '0;
  framer_mode_e mode_now      = MODE_IDLE;
  logic [7:0]   held_bytes [jbf_pkg::PREFIX_LEN];
  int unsigned  held_now      = 0;
  bit           header_now    = 1'b0;
  logic [31:0]  length_now    = '0;
  logic [31:0]  payload_now   = '0;
  len_phase_e   len_now       = LEN_WAIT;

  jbf_pkg::res_t expected_results [$];
  logic [7:0]    byte_backlog [$];
  int unsigned   pushed_total   = 0;
  int unsigned   mismatch_count = 0;

  function automatic void expect_result(logic [7:0] b, logic [1:0] kind, logic fin,
                                        logic [1:0] err);
    jbf_pkg::res_t r;
    r.out_byte   = b;
    r.out_kind   = kind;
    r.frame_end  = fin;
    r.error_code = err;
    expected_results.push_back(r);
  endfunction

  function automatic void drop_frame();
    depth_now   = 0;
    mode_now    = MODE_IDLE;
    held_now    = 0;
    header_now  = 1'b0;
    length_now  = '0;
    payload_now = '0;
    len_now     = LEN_WAIT;
  endfunction

  // Accumulate the decimal value of a raw header, saturating at the length width.
  function automatic void accumulate_length(logic [7:0] b);
    logic [63:0] v;
    logic [63:0] cap;
    bit          digit;
    cap   = (64'd1 << jbf_pkg::LEN_BITS) - 64'd1;
    digit = (b >= jbf_pkg::CH_ZERO) && (b <= jbf_pkg::CH_NINE);
    case (len_now)
      LEN_WAIT: begin
        if (digit) begin
          len_now = LEN_DIGITS;
        end else begin
          if (b != jbf_pkg::CH_SPACE && b != jbf_pkg::CH_TAB && b != jbf_pkg::CH_QUOTE)
            len_now = LEN_NONE;
          return;
        end
      end
      LEN_DIGITS: begin
        if (!digit) begin
          len_now = LEN_DONE;
          return;
        end
      end
      default: return;
    endcase
    v = {32'd0, length_now} * 64'd10 + 64'(b - jbf_pkg::CH_ZERO);
    if (v > cap) v = cap;
    length_now = v[31:0];
  endfunction

  function automatic void frame_byte(logic [7:0] b);
    bit         esc;
    bit         closed;
    bit         match_tag;
    bit         release_burst;
    logic [1:0] kind;
    logic [1:0] end_err;
    release_burst = 1'b0;
    esc       = (last_byte == jbf_pkg::CH_BSLASH);
    last_byte = b;

    case (mode_now)
      MODE_IDLE: begin
        if (b == jbf_pkg::CH_OPEN && !esc) begin
          drop_frame();
          mode_now      = MODE_OBJECT;
          depth_now     = 1;
          held_bytes[0] = b;
          held_now      = 1;
        end else if (b == jbf_pkg::CH_CLOSE && !esc) begin
          expect_result(8'h00, jbf_pkg::KIND_STATUS, 1'b0, jbf_pkg::ERR_UNBAL);
          drop_frame();
        end
        return;
      end
      MODE_SKIP: begin
        mode_now = MODE_IDLE;
        return;
      end
      MODE_PAYLOAD: begin
        if (payload_now <= 32'd1) begin
          expect_result(b, jbf_pkg::KIND_PAYLOAD, 1'b1, jbf_pkg::ERR_NONE);
          payload_now = '0;
          mode_now    = shadow_skip ? MODE_SKIP : MODE_IDLE;
        end else begin
          expect_result(b, jbf_pkg::KIND_PAYLOAD, 1'b0, jbf_pkg::ERR_NONE);
          payload_now = payload_now - 32'd1;
        end
        return;
      end
      default: ;
    endcase

    // Inside an object.
    if (b == jbf_pkg::CH_OPEN && !esc) begin
      if (depth_now >= jbf_pkg::MAX_DEPTH) begin
        expect_result(8'h00, jbf_pkg::KIND_STATUS, 1'b0, jbf_pkg::ERR_OVERFLOW);
        drop_frame();
        return;
      end
      depth_now++;
    end else if (b == jbf_pkg::CH_CLOSE && !esc) begin
      if (depth_now > 0) depth_now--;
    end
    closed = (depth_now == 0);

    if (held_now < jbf_pkg::PREFIX_LEN) begin
      held_bytes[held_now] = b;
      held_now++;
      if (held_now == jbf_pkg::PREFIX_LEN) begin
        match_tag = shadow_raw_en;
        for (int i = 0; i < jbf_pkg::PREFIX_LEN; i++)
          if (held_bytes[i] != jbf_pkg::RAW_TAG[i]) match_tag = 1'b0;
        header_now = match_tag;
      end else if (!closed) begin
        return;
      end
      release_burst = 1'b1;
    end else if (header_now) begin
      accumulate_length(b);
    end

    // A header closing without digits flags its last byte.
    end_err = (closed && header_now && len_now != LEN_DIGITS && len_now != LEN_DONE) ?
              jbf_pkg::ERR_BAD_LEN : jbf_pkg::ERR_NONE;
    kind    = header_now ? jbf_pkg::KIND_HEADER : jbf_pkg::KIND_OBJECT;

    if (release_burst) begin
      for (int i = 0; i < held_now; i++) begin
        if (closed && i + 1 == held_now) expect_result(held_bytes[i], kind, 1'b1, end_err);
        else expect_result(held_bytes[i], kind, 1'b0, jbf_pkg::ERR_NONE);
      end
    end else begin
      expect_result(b, kind, closed, end_err);
    end

    if (closed) begin
      if (header_now && end_err == jbf_pkg::ERR_NONE) begin
        payload_now = length_now;
        if (payload_now != 0) mode_now = MODE_PAYLOAD;
        else mode_now = shadow_skip ? MODE_SKIP : MODE_IDLE;
      end else begin
        mode_now = MODE_IDLE;
      end
      depth_now  = 0;
      held_now   = 0;
      header_now = 1'b0;
      length_now = '0;
      len_now    = LEN_WAIT;
    end
  endfunction

  // ------------------------------------------------------------------
  // Mismatch reporting and result checks.
  // ------------------------------------------------------------------
  task automatic flag_mismatch(string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic check_result(logic [7:0] b, logic [1:0] kind, logic fin, logic [1:0] err);
    jbf_pkg::res_t want;
    if (expected_results.size() == 0) begin
      flag_mismatch($sformatf("unexpected result byte=%02h kind=%0d end=%0b err=%0d",
                              b, kind, fin, err));
      return;
    end
    want = expected_results.pop_front();
    if (b !== want.out_byte)
      flag_mismatch($sformatf("out_byte %02h, expected %02h", b, want.out_byte));
    if (kind !== want.out_kind)
      flag_mismatch($sformatf("out_kind %0d, expected %0d (byte %02h)", kind, want.out_kind,
                              want.out_byte));
    if (fin !== want.frame_end)
      flag_mismatch($sformatf("frame_end %0b, expected %0b (byte %02h)", fin, want.frame_end,
                              want.out_byte));
    if (err !== want.error_code)
      flag_mismatch($sformatf("error_code %0d, expected %0d (byte %02h)", err,
                              want.error_code, want.out_byte));
  endtask

  // Mostly short gaps, a few long ones, none while a calm stretch lasts.
  function automatic int unsigned pick_gap(bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  // ------------------------------------------------------------------
  // Request driver: feed the backlog into in_if, one byte per request.
  // ------------------------------------------------------------------
  int unsigned send_gap  = 0;
  bit          send_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid   <= 1'b0;
      in_if.in_byte <= '0;
      send_gap      <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      // Predict on acceptance, then pick what goes out next.
      if (in_if.valid) frame_byte(in_if.in_byte);
      if ($urandom_range(0, 47) == 0) send_calm = !send_calm;
      if (send_gap != 0) begin
        send_gap    <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if (byte_backlog.size() != 0) begin
        in_if.valid   <= 1'b1;
        in_if.in_byte <= byte_backlog.pop_front();
        send_gap      <= pick_gap(send_calm);
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ------------------------------------------------------------------
  // Result monitor: check every accepted result, stall ready at random.
  // ------------------------------------------------------------------
  int unsigned take_stall = 0;
  bit          take_calm  = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      take_stall   <= 0;
    end else begin
      if (out_if.valid && out_if.ready)
        check_result(out_if.out_byte, out_if.out_kind, out_if.frame_end, out_if.error_code);
      if ($urandom_range(0, 47) == 0) take_calm = !take_calm;
      if (take_stall != 0) begin
        take_stall   <= take_stall - 1;
        out_if.ready <= 1'b0;
      end else if (!take_calm && $urandom_range(0, 99) < 20) begin
        take_stall   <= pick_gap(1'b0);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------
  // Stimulus builders: append bytes to the backlog.
  // ------------------------------------------------------------------
  task automatic push_byte(logic [7:0] b);
    byte_backlog.push_back(b);
    pushed_total++;
  endtask

  task automatic push_text(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  // Printable object text, a few high bytes, never a brace or a backslash.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    if ($urandom_range(0, 9) == 0) b = 8'($urandom_range(128, 255));
    else b = 8'($urandom_range(32, 126));
    if (b == jbf_pkg::CH_OPEN || b == jbf_pkg::CH_CLOSE || b == jbf_pkg::CH_BSLASH) b = 8'h5F;
    return b;
  endfunction

  function automatic int unsigned pick_length();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return $urandom_range(20, 48);
    return $urandom_range(1, 12);
  endfunction

  // Raw header with a value in one of several spellings, its payload, maybe a separator.
  task automatic queue_raw_frame(int unsigned len);
    int unsigned style;
    logic [7:0]  b;
    bit          taken;
    style = $urandom_range(0, 3);
    taken = shadow_raw_en;
    push_text("{\"RAW\":");
    case (style)
      1: push_byte(jbf_pkg::CH_SPACE);
      2: push_byte(jbf_pkg::CH_QUOTE);
      3: push_byte(jbf_pkg::CH_TAB);
      default: ;
    endcase
    push_text($sformatf("%0d", len));
    if (style == 2) push_byte(jbf_pkg::CH_QUOTE);
    if (style == 3) push_text(",\"id\":42");
    push_byte(jbf_pkg::CH_CLOSE);
    // Keep stray open braces out of bytes that land outside any frame.
    repeat (len) begin
      b = 8'($urandom_range(0, 255));
      if (!taken && b == jbf_pkg::CH_OPEN) b = jbf_pkg::CH_CLOSE;
      push_byte(b);
    end
    if (shadow_skip) begin
      case ($urandom_range(0, 2))
        0: push_byte(CH_NEWLINE);
        1: push_byte(taken ? jbf_pkg::CH_OPEN : CH_NEWLINE);
        default: push_byte(CH_FILL);
      endcase
    end else if ($urandom_range(0, 1) == 1) begin
      push_byte(CH_NEWLINE);
    end
  endtask

  task automatic queue_object();
    int unsigned n;
    n = $urandom_range(1, 14);
    push_byte(jbf_pkg::CH_OPEN);
    repeat (n) begin
      case ($urandom_range(0, 19))
        0: push_text("{\"k\":[1]}");
        1: push_text("\\}");
        2: push_text("\\{");
        default: push_byte(text_byte());
      endcase
    end
    push_byte(jbf_pkg::CH_CLOSE);
  endtask

  task automatic queue_short_object();
    push_byte(jbf_pkg::CH_OPEN);
    repeat ($urandom_range(0, 4)) push_byte(text_byte());
    push_byte(jbf_pkg::CH_CLOSE);
  endtask

  task automatic queue_noise();
    logic [7:0] b;
    repeat ($urandom_range(1, 6)) begin
      b = 8'($urandom_range(0, 255));
      if (b == jbf_pkg::CH_OPEN) b = jbf_pkg::CH_CLOSE;
      push_byte(b);
    end
  endtask

  task automatic queue_broken();
    case ($urandom_range(0, 5))
      0: push_byte(jbf_pkg::CH_CLOSE);
      1: push_text("{\"RAW\":}");
      2: push_text("{\"RAW\":\"x\"}");
      3: push_text("\\{zz");
      4: push_text("{\"RAw\":3}");
      default: begin
        // Unfinished object swallows the next one; close it by hand.
        push_text("{\"a\":");
        queue_object();
        push_byte(jbf_pkg::CH_CLOSE);
      end
    endcase
  endtask

  // Hold until every request is taken and every result is back, then let the
  // framer run quiet for a while.
  task automatic settle();
    while (byte_backlog.size() != 0 || in_if.valid || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (QUIET_CYCLES) @(posedge clk_i);
  endtask

  // Feed whatever the shadow state needs to get the framer back outside any frame.
  task automatic return_to_idle();
    settle();
    while (mode_now != MODE_IDLE) begin
      case (mode_now)
        MODE_OBJECT: begin
          if (last_byte == jbf_pkg::CH_BSLASH) push_byte(CH_FILL);
          repeat (depth_now) push_byte(jbf_pkg::CH_CLOSE);
        end
        MODE_PAYLOAD: repeat (payload_now) push_byte(CH_FILL);
        default: push_byte(CH_FILL);
      endcase
      settle();
    end
  endtask

  task automatic write_register(logic [jbf_pkg::CFG_IDX_W-1:0] idx, bit value);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= jbf_pkg::CFG_DATA_W'(value);
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      jbf_pkg::CFG_RAW_ENABLE: shadow_raw_en = value;
      jbf_pkg::CFG_SKIP_AFTER: shadow_skip   = value;
      default: ;
    endcase
  endtask

  // Mix of well-formed frames with random content, noise and broken frames.
  // Halfway through, hold the sender until the framer has caught up.
  task automatic random_phase(int unsigned budget);
    int unsigned first;
    int unsigned r;
    bit          paused;
    first  = pushed_total;
    paused = 1'b0;
    while (pushed_total - first < budget) begin
      if (!paused && pushed_total - first >= budget / 2) begin
        settle();
        paused = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 35) queue_raw_frame(pick_length());
      else if (r < 62) queue_object();
      else if (r < 72) queue_short_object();
      else if (r < 84) queue_noise();
      else queue_broken();
    end
  endtask

  // Walk up to the depth limit and one past it.
  task automatic queue_deep_nesting();
    push_text("{\"deep\":");
    repeat (jbf_pkg::MAX_DEPTH - 1) push_byte(jbf_pkg::CH_OPEN);
    push_byte(CH_FILL);
    push_byte(jbf_pkg::CH_OPEN);
    push_byte(CH_NEWLINE);
  endtask

  // ------------------------------------------------------------------
  // Test sequence.
  // ------------------------------------------------------------------
  initial begin
    rst_ni        = 1'b0;
    in_if.valid   = 1'b0;
    in_if.in_byte = '0;
    out_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed cases under the reset settings.
    push_byte(jbf_pkg::CH_CLOSE);                     // stray close brace
    push_text("{}");                                  // short object
    push_text("{\"RAW\":2}");                         // header, payload of both extremes
    push_byte(8'h00);
    push_byte(8'hFF);
    push_byte(CH_NEWLINE);                            // separator dropped
    push_text("{\"RAW\":}");                          // no digits: bad length
    push_text("{\"RAW\":0}");                         // zero length, skip eats the brace
    push_byte(jbf_pkg::CH_OPEN);
    push_text("\\{");                                 // escaped open outside a frame
    push_text("{\"a\":\"\\}\"}");                     // escaped close inside
    push_text("{\"RAW\":1}q\\{}");                    // escape carried over a skipped byte
    return_to_idle();

    write_register(jbf_pkg::CFG_RAW_ENABLE, 1'b0);
    random_phase(PHASE_BYTES);
    return_to_idle();

    write_register(jbf_pkg::CFG_RAW_ENABLE, 1'b1);
    write_register(jbf_pkg::CFG_SKIP_AFTER, 1'b0);
    random_phase(PHASE_BYTES);
    return_to_idle();

    write_register(jbf_pkg::CFG_RAW_ENABLE, 1'b0);
    random_phase(PHASE_BYTES);
    return_to_idle();

    write_register(jbf_pkg::CFG_RAW_ENABLE, 1'b1);
    write_register(jbf_pkg::CFG_SKIP_AFTER, 1'b1);
    random_phase(PHASE_BYTES);
    return_to_idle();
    queue_deep_nesting();
    return_to_idle();

    // Saturating length goes last: its payload never ends within the run.
    push_text("{\"RAW\": \"98765432109876\"}");
    repeat (4) push_byte(8'($urandom_range(0, 255)));
    settle();

    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("[json_brace_framer_with_raw_core] OK");
    end else begin
      $display("[json_brace_framer_with_raw_core] ERROR");
    end
    $finish;
  end

  initial begin
    #(LIMIT_NS);
    $display("[json_brace_framer_with_raw_core] ERROR");
    $finish;
  end

endmodule
